// ===== design/tpc_pkg.sv =====
// Shared constants, types and register codes for the touch point calibrator.
// No dependencies; used by tpc_coord_map and touch_point_calibrator.
`default_nettype none

package tpc_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;

    localparam int RAW_W   = 12;               // one ADC conversion
    localparam int COEF_W  = 32;               // Q16.16 coefficient
    localparam int FRAC_W  = 16;
    localparam int PIX_W   = 12;               // clamped pixel, screens up to 4096
    localparam int PX_W    = 9;                // point_x field
    localparam int PY_W    = 8;                // point_y field
    localparam int PROD_W  = COEF_W + RAW_W + 1;
    localparam int ACC_W   = PROD_W + 2;
    localparam int IDX_W   = 3;

    localparam logic [RAW_W-1:0]  FAIL_MARK   = 12'hFFF;
    localparam logic [RAW_W-1:0]  LIMIT_RESET = 12'd1200;
    localparam logic [COEF_W-1:0] GAIN_ONE    = 32'h0001_0000;

    localparam logic [PIX_W-1:0] X_MAX = PIX_W'(SCREEN_WIDTH - 1);
    localparam logic [PIX_W-1:0] Y_MAX = PIX_W'(SCREEN_HEIGHT - 1);

    localparam logic [IDX_W-1:0] CFG_COEF_XX  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_COEF_XY  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_OFFSET_X = 3'd2;
    localparam logic [IDX_W-1:0] CFG_COEF_YX  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_COEF_YY  = 3'd4;
    localparam logic [IDX_W-1:0] CFG_OFFSET_Y = 3'd5;
    localparam logic [IDX_W-1:0] CFG_PRES_LIM = 3'd6;

    typedef struct packed {
        logic mul_en;   // load products from the input stage
        logic sum_en;   // load clamped pixel from the products
    } t_stage_en;

endpackage

`default_nettype wire

// ===== design/tpc_coord_map.sv =====
// One screen coordinate: two Q16.16 products, offset sum, clamp and floor.
// Two register stages; depends on tpc_pkg.
`default_nettype none

module tpc_coord_map (
    input  wire                                i_clk,
    input  wire tpc_pkg::t_stage_en            i_en,
    input  wire [tpc_pkg::RAW_W-1:0]           i_avg_x,
    input  wire [tpc_pkg::RAW_W-1:0]           i_avg_y,
    input  wire [tpc_pkg::COEF_W-1:0]          i_gain_a,
    input  wire [tpc_pkg::COEF_W-1:0]          i_gain_b,
    input  wire [tpc_pkg::COEF_W-1:0]          i_offset,
    input  wire [tpc_pkg::PIX_W-1:0]           i_max,
    output logic [tpc_pkg::PIX_W-1:0]          o_pixel
);

    logic signed [tpc_pkg::PROD_W-1:0] r_prod_a, r_prod_b;
    logic signed [tpc_pkg::COEF_W-1:0] r_offset;
    logic signed [tpc_pkg::ACC_W-1:0]  w_acc;
    logic        [tpc_pkg::ACC_W-1:0]  w_top;
    logic        [tpc_pkg::PIX_W-1:0]  n_pixel, r_pixel;

    always_ff @(posedge i_clk) begin
        if (i_en.mul_en) begin
            r_prod_a <= $signed(i_gain_a) * $signed({1'b0, i_avg_x});
            r_prod_b <= $signed(i_gain_b) * $signed({1'b0, i_avg_y});
            r_offset <= $signed(i_offset);
        end
    end

    assign w_acc = {{2{r_prod_a[tpc_pkg::PROD_W-1]}}, r_prod_a}
                 + {{2{r_prod_b[tpc_pkg::PROD_W-1]}}, r_prod_b}
                 + {{(tpc_pkg::ACC_W-tpc_pkg::COEF_W){r_offset[tpc_pkg::COEF_W-1]}}, r_offset};

    assign w_top = {{(tpc_pkg::ACC_W-tpc_pkg::PIX_W-tpc_pkg::FRAC_W){1'b0}},
                    i_max, {tpc_pkg::FRAC_W{1'b0}}};

    // below zero clamps to 0; past the last pixel clamps to it; else floor
    always_comb begin
        if (w_acc[tpc_pkg::ACC_W-1]) begin
            n_pixel = '0;
        end else if (unsigned'(w_acc) > w_top) begin
            n_pixel = i_max;
        end else begin
            n_pixel = w_acc[tpc_pkg::FRAC_W +: tpc_pkg::PIX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.sum_en) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_pixel = r_pixel;

endmodule

`default_nettype wire

// ===== design/touch_point_calibrator.sv =====
// Touch point calibrator: sample qualification, pair averaging, affine map.
// Each accepted beat moves through the input, product, pixel and output registers.
// Throughput: one sample per cycle while m_axis_tready holds high; each register
// advances when the stage after it is empty or moving, so gaps close up.
// Reset (i_rst_n, synchronous): pipeline emptied, identity gains, zero offsets,
// pressure limit 1200, held point (0,0). Depends on tpc_pkg, tpc_coord_map.
`default_nettype none

module touch_point_calibrator (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [11:0] pressure, [23:12] x_first, [35:24] y_first,
    // [47:36] x_second, [59:48] y_second, [63:60] zero
    input  wire  [63:0] s_axis_tdata,
    // [0] pen_down
    input  wire  [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [8:0] point_x, [16:9] point_y, [23:17] zero
    output logic [23:0] m_axis_tdata,
    // [0] pressed
    output logic [0:0]  m_axis_tuser,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [tpc_pkg::IDX_W-1:0]  i_cfg_index,
    input  wire  [tpc_pkg::COEF_W-1:0] i_cfg_data
);

    logic [tpc_pkg::COEF_W-1:0] r_coef_xx, r_coef_xy, r_offset_x;
    logic [tpc_pkg::COEF_W-1:0] r_coef_yx, r_coef_yy, r_offset_y;
    logic [tpc_pkg::RAW_W-1:0]  r_pres_lim;

    logic r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    logic r_s1_touch, r_s2_touch, r_s3_touch, r_out_pressed;
    logic w_out_en, w_s3_en, w_s2_en, w_s1_en;

    logic [tpc_pkg::RAW_W-1:0] w_pres, w_x1, w_y1, w_x2, w_y2;
    logic [tpc_pkg::RAW_W:0]   w_sum_x, w_sum_y;
    logic                      w_touch;
    logic [tpc_pkg::RAW_W-1:0] r_avg_x, r_avg_y;

    logic [tpc_pkg::PIX_W-1:0] w_pix_x, w_pix_y;
    logic [tpc_pkg::PX_W-1:0]  r_held_x;
    logic [tpc_pkg::PY_W-1:0]  r_held_y;

    tpc_pkg::t_stage_en w_en;

    // configuration: always ready; writes must land while the pipeline is idle, which the block does not enforce
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_xx  <= tpc_pkg::GAIN_ONE;
            r_coef_xy  <= '0;
            r_offset_x <= '0;
            r_coef_yx  <= '0;
            r_coef_yy  <= tpc_pkg::GAIN_ONE;
            r_offset_y <= '0;
            r_pres_lim <= tpc_pkg::LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tpc_pkg::CFG_COEF_XX:  r_coef_xx  <= i_cfg_data;
                tpc_pkg::CFG_COEF_XY:  r_coef_xy  <= i_cfg_data;
                tpc_pkg::CFG_OFFSET_X: r_offset_x <= i_cfg_data;
                tpc_pkg::CFG_COEF_YX:  r_coef_yx  <= i_cfg_data;
                tpc_pkg::CFG_COEF_YY:  r_coef_yy  <= i_cfg_data;
                tpc_pkg::CFG_OFFSET_Y: r_offset_y <= i_cfg_data;
                tpc_pkg::CFG_PRES_LIM: r_pres_lim <= i_cfg_data[tpc_pkg::RAW_W-1:0];
                default: ;
            endcase
        end
    end

    // stage enables: a stage moves when the one after it is empty or moving
    assign w_out_en = !r_out_valid || m_axis_tready;
    assign w_s3_en  = !r_s3_valid || w_out_en;
    assign w_s2_en  = !r_s2_valid || w_s3_en;
    assign w_s1_en  = !r_s1_valid || w_s2_en;
    assign s_axis_tready = w_s1_en;

    assign w_en.mul_en = w_s2_en;
    assign w_en.sum_en = w_s3_en;

    assign w_pres = s_axis_tdata[11:0];
    assign w_x1   = s_axis_tdata[23:12];
    assign w_y1   = s_axis_tdata[35:24];
    assign w_x2   = s_axis_tdata[47:36];
    assign w_y2   = s_axis_tdata[59:48];

    assign w_touch = s_axis_tuser[0] && (w_pres < r_pres_lim)
                  && (w_x1 != tpc_pkg::FAIL_MARK) && (w_y1 != tpc_pkg::FAIL_MARK);
    assign w_sum_x = {1'b0, w_x1} + {1'b0, w_x2};
    assign w_sum_y = {1'b0, w_y1} + {1'b0, w_y2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_en)  r_s1_valid  <= s_axis_tvalid;
            if (w_s2_en)  r_s2_valid  <= r_s1_valid;
            if (w_s3_en)  r_s3_valid  <= r_s2_valid;
            if (w_out_en) r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_en) begin
            r_s1_touch <= w_touch;
            r_avg_x    <= w_sum_x[tpc_pkg::RAW_W:1];
            r_avg_y    <= w_sum_y[tpc_pkg::RAW_W:1];
        end
        if (w_s2_en) r_s2_touch <= r_s1_touch;
        if (w_s3_en) r_s3_touch <= r_s2_touch;
    end

    tpc_coord_map u_map_x (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_avg_x  (r_avg_x),
        .i_avg_y  (r_avg_y),
        .i_gain_a (r_coef_xx),
        .i_gain_b (r_coef_xy),
        .i_offset (r_offset_x),
        .i_max    (tpc_pkg::X_MAX),
        .o_pixel  (w_pix_x)
    );

    tpc_coord_map u_map_y (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_avg_x  (r_avg_x),
        .i_avg_y  (r_avg_y),
        .i_gain_a (r_coef_yx),
        .i_gain_b (r_coef_yy),
        .i_offset (r_offset_y),
        .i_max    (tpc_pkg::Y_MAX),
        .o_pixel  (w_pix_y)
    );

    // held point updates in sample order as each pressed beat enters the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_x <= '0;
            r_held_y <= '0;
        end else if (w_out_en && r_s3_valid && r_s3_touch) begin
            r_held_x <= w_pix_x[tpc_pkg::PX_W-1:0];
            r_held_y <= w_pix_y[tpc_pkg::PY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_en) begin
            r_out_pressed <= r_s3_touch;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_pressed;
    assign m_axis_tdata  = {7'b0, r_held_y, r_held_x};

endmodule

`default_nettype wire
